/* rtl/pams_pkg.sv */
// Package for the potentiometer averaging, motor and servo pulse block.
// Holds field widths, the register map, scaling constants, reciprocal divider
// constants and the lane status struct. No dependencies.
package pams_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int SCALED_W  = 8;
    localparam int SETTING_W = 8;
    localparam int ABS_SPD_W = 7;
    localparam int ABS_ANG_W = 8;
    localparam int PERIOD_W  = 16;
    localparam int MPULSE_W  = 16;
    localparam int SPULSE_W  = 14;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;

    // Configuration register map (word index taken from paddr[2])
    localparam logic REG_MOTOR_PERIOD = 1'b0;

    // Scaling constants
    localparam int SPEED_SCALE  = 198;
    localparam int ANGLE_SCALE  = 180;
    localparam int SPEED_OFFSET = 99;
    localparam int ANGLE_OFFSET = 90;
    localparam int SERVO_STEP   = 50;
    localparam int SERVO_BASE   = 2999;

    // scale * average stays below 2^18.
    localparam int SCL_W = 18;

    // Division by 1023 as a multiply by ceil(2^28/1023) and a shift; exact for
    // every dividend below 2^18.
    localparam int DIV1023_SHIFT = 28;
    localparam int DIV1023_MUL_W = 19;
    localparam int DIV1023_MUL_I = (2**DIV1023_SHIFT + 1023 - 1) / 1023;
    localparam logic [DIV1023_MUL_W-1:0] DIV1023_MUL = DIV1023_MUL_I[DIV1023_MUL_W-1:0];
    localparam int DIV1023_P_W = SCL_W + DIV1023_MUL_W;

    // Division by 100 as a multiply by ceil(2^30/100) and a shift; exact for
    // every dividend below 2^23 (abs_speed * period is at most 6487965).
    localparam int MPROD_W      = 23;
    localparam int DIV100_SHIFT = 30;
    localparam int DIV100_MUL_W = 24;
    localparam int DIV100_MUL_I = (2**DIV100_SHIFT + 100 - 1) / 100;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = DIV100_MUL_I[DIV100_MUL_W-1:0];
    localparam int DIV100_P_W = MPROD_W + DIV100_MUL_W;

    // Status a lane hands to the merge stage.
    typedef struct packed {
        logic                done;
        logic [SCALED_W-1:0] value;
    } lane_res_t;

endpackage

/* rtl/pot_average_motor_servo_pwm.sv */
// Top level of the potentiometer averaging, motor and servo pulse block.
// Instantiates two pams_lane averaging lanes and the pams_merge stage;
// depends on pams_pkg.
//
//  Port group   Direction  Beat contents
//  -----------  ---------  --------------------------------------------------
//  s_t*         in         speed_sample, angle_sample
//  m_t*         out        speed/angle settings, magnitudes, bridge bits,
//                          motor_pulse, servo_pulse
//  APB p*       in/out     motor_period register at byte address 0
//
// A new input beat is accepted only after the previous result has been loaded
// into the output register. The ring sweep reads one stored sample per cycle
// from each lane's memory, then the lanes close the sum and run three multiply
// stages, and the merge takes three more steps before the result is offered.
// Reset is synchronous and active low; it clears both rings (through per-entry
// valid bits), the write slot and motor_period. A stalled result waits in the
// output register while the next input beat is already accepted.
module pot_average_motor_servo_pwm
    import pams_pkg::*;
#(
    parameter int AVG_DEPTH = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [9:0] speed_sample, [19:10] angle_sample
    // Result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] speed_setting, [14:8] abs_speed, [22:15] angle_setting,
    // [30:23] abs_angle, [31] drive_reverse, [32] drive_forward,
    // [48:33] motor_pulse, [62:49] servo_pulse
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(AVG_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(AVG_DEPTH - 1);

    // Sequencer: wait for a beat, run the lanes, then hand over to the merge.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LANES = 3'b010,
        ST_MERGE = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   write_slot_reg;
    logic [PERIOD_W-1:0] motor_period_reg;
    logic                s_accept;
    logic                cfg_write;
    logic                merge_start;
    logic                merge_loaded;
    lane_res_t           spd_res;
    lane_res_t           ang_res;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign merge_start = (state_reg == ST_LANES) && spd_res.done;

    // The APB port never stalls; the register sits at word index zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MOTOR_PERIOD) ? {16'b0, motor_period_reg} : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_LANES;
                end
            end
            ST_LANES: begin
                if (spd_res.done) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (merge_loaded) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            write_slot_reg   <= '0;
            motor_period_reg <= '0;
        end else begin
            state_reg <= state_next;
            // The slot advances on each accepted beat and wraps after the
            // last ring entry.
            if (s_accept) begin
                write_slot_reg <= (write_slot_reg == LAST_SLOT) ? '0
                                                                : write_slot_reg + 1'b1;
            end
            if (cfg_write && (paddr[2] == REG_MOTOR_PERIOD)) begin
                motor_period_reg <= pwdata[PERIOD_W-1:0];
            end
        end
    end

    // Speed and angle lanes run in lockstep on the same beat.
    pams_lane #(
        .AVG_DEPTH (AVG_DEPTH),
        .SCALE     (SPEED_SCALE)
    ) u_spd_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (s_accept),
        .slot_i   (write_slot_reg),
        .sample_i (s_tdata[SAMPLE_W-1:0]),
        .res_o    (spd_res)
    );

    pams_lane #(
        .AVG_DEPTH (AVG_DEPTH),
        .SCALE     (ANGLE_SCALE)
    ) u_ang_lane (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (s_accept),
        .slot_i   (write_slot_reg),
        .sample_i (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .res_o    (ang_res)
    );

    pams_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (merge_start),
        .spd_i     (spd_res),
        .ang_i     (ang_res),
        .period_i  (motor_period_reg),
        .m_ready_i (m_tready),
        .m_valid_o (m_tvalid),
        .m_data_o  (m_tdata),
        .loaded_o  (merge_loaded)
    );

    // The write slot never points past the last ring entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        write_slot_reg <= LAST_SLOT)
        else $error("write slot out of range");

    // An accepted beat closes the input until its result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted twice for one item");

    // Both lanes finish in the same cycle, and only while the sequencer waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (spd_res.done == ang_res.done) && (!spd_res.done || state_reg == ST_LANES))
        else $error("lane completion out of step");

    // The bridge never gets both direction bits at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[31] && m_tdata[32]))
        else $error("both bridge direction bits set");

endmodule

/* rtl/pams_lane.sv */
// One averaging lane: sample ring, sequential sum, reciprocal average and
// scaling to a truncated 0..SCALE result. Depends on pams_pkg.
module pams_lane
    import pams_pkg::*;
#(
    parameter int AVG_DEPTH = 10,
    parameter int SCALE     = 198
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start_i,
    input  logic [$clog2(AVG_DEPTH)-1:0] slot_i,
    input  logic [SAMPLE_W-1:0]          sample_i,
    output lane_res_t                    res_o
);

    localparam int ADDR_W    = $clog2(AVG_DEPTH);
    localparam int SUM_W     = $clog2(AVG_DEPTH * (2**SAMPLE_W - 1) + 1);
    localparam int AVG_SHIFT = SUM_W + ADDR_W;
    localparam int AVG_MUL_I = (2**AVG_SHIFT + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [SUM_W:0] AVG_MUL = AVG_MUL_I[SUM_W:0];
    localparam int PROD_W    = 2 * SUM_W + 1;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(AVG_DEPTH - 1);
    localparam logic [SCL_W-1:0]  SCALE_K  = SCL_W'(SCALE);

    logic [SAMPLE_W-1:0]    ring_mem [AVG_DEPTH];
    logic [AVG_DEPTH-1:0]   ring_vld_reg;
    logic                   rd_act_reg;
    logic [ADDR_W-1:0]      rd_idx_reg;
    logic [SAMPLE_W-1:0]    rd_dat_reg;
    logic                   rd_ok_reg;
    logic                   dat_vld_reg;
    logic                   dat_last_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic                   sum_done_reg;
    logic [PROD_W-1:0]      avg_prod_reg;
    logic                   avg_vld_reg;
    logic [SCL_W-1:0]       scl_reg;
    logic                   scl_vld_reg;
    logic [DIV1023_P_W-1:0] div_prod_reg;
    logic                   done_reg;
    logic [SAMPLE_W-1:0]    avg;
    logic [SAMPLE_W-1:0]    add_val;

    assign avg     = avg_prod_reg[AVG_SHIFT +: SAMPLE_W];
    assign add_val = rd_ok_reg ? rd_dat_reg : '0;

    // Ring storage: one write on accept, one registered read per sweep step.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            ring_mem[slot_i] <= sample_i;
        end
        if (rd_act_reg) begin
            rd_dat_reg <= ring_mem[rd_idx_reg];
        end
    end

    // Sweep and stage control. An entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
            rd_act_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            rd_ok_reg    <= 1'b0;
            dat_vld_reg  <= 1'b0;
            dat_last_reg <= 1'b0;
            sum_done_reg <= 1'b0;
            avg_vld_reg  <= 1'b0;
            scl_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            if (start_i) begin
                ring_vld_reg[slot_i] <= 1'b1;
                rd_act_reg           <= 1'b1;
                rd_idx_reg           <= '0;
            end else if (rd_act_reg) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_IDX) begin
                    rd_act_reg <= 1'b0;
                end
            end
            rd_ok_reg    <= ring_vld_reg[rd_idx_reg];
            dat_vld_reg  <= rd_act_reg;
            dat_last_reg <= rd_act_reg && (rd_idx_reg == LAST_IDX);
            sum_done_reg <= dat_vld_reg && dat_last_reg;
            avg_vld_reg  <= sum_done_reg;
            scl_vld_reg  <= avg_vld_reg;
            done_reg     <= scl_vld_reg;
        end
    end

    // Datapath: accumulate, divide by the depth, scale, divide by 1023.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            sum_reg <= '0;
        end else if (dat_vld_reg) begin
            sum_reg <= sum_reg + SUM_W'(add_val);
        end
        if (sum_done_reg) begin
            avg_prod_reg <= PROD_W'(sum_reg) * PROD_W'(AVG_MUL);
        end
        if (avg_vld_reg) begin
            scl_reg <= SCL_W'(avg) * SCALE_K;
        end
        if (scl_vld_reg) begin
            div_prod_reg <= DIV1023_P_W'(scl_reg) * DIV1023_P_W'(DIV1023_MUL);
        end
    end

    assign res_o.done  = done_reg;
    assign res_o.value = div_prod_reg[DIV1023_SHIFT +: SCALED_W];

endmodule

/* rtl/pams_merge.sv */
// Merge stage: combines the speed and angle lane results into settings,
// bridge direction bits, motor and servo compare values, and the output
// register. Depends on pams_pkg.
module pams_merge
    import pams_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start_i,
    input  lane_res_t             spd_i,
    input  lane_res_t             ang_i,
    input  logic [PERIOD_W-1:0]   period_i,
    input  logic                  m_ready_i,
    output logic                  m_valid_o,
    output logic [OUT_DATA_W-1:0] m_data_o,
    output logic                  loaded_o
);

    logic signed [SCALED_W:0]      spd_s;
    logic        [SCALED_W:0]      spd_abs;
    logic signed [SETTING_W-1:0]   speed_reg;
    logic        [ABS_SPD_W-1:0]   abs_spd_reg;
    logic signed [SETTING_W-1:0]   angle_reg;
    logic        [ABS_ANG_W-1:0]   abs_ang_reg;
    logic                          rev_reg;
    logic                          fwd_reg;
    logic        [SPULSE_W-1:0]    servo_reg;
    logic        [MPROD_W-1:0]     mprod_reg;
    logic        [DIV100_P_W-1:0]  qprod_reg;
    logic                          a_vld_reg;
    logic                          b_vld_reg;
    logic                          m_valid_reg;
    logic        [OUT_DATA_W-1:0]  m_data_reg;
    logic                          load;

    assign spd_s   = $signed({1'b0, spd_i.value}) - (SCALED_W+1)'(SPEED_OFFSET);
    assign spd_abs = spd_s[SCALED_W] ? (SCALED_W+1)'(-spd_s) : (SCALED_W+1)'(spd_s);
    assign load    = b_vld_reg && (!m_valid_reg || m_ready_i);

    // First step: signed settings, magnitudes, bridge bits, servo value and the motor product.
    always_ff @(posedge aclk) begin
        if (start_i) begin
            speed_reg   <= SETTING_W'(spd_s);
            abs_spd_reg <= ABS_SPD_W'(spd_abs);
            angle_reg   <= SETTING_W'(ang_i.value) - SETTING_W'(ANGLE_OFFSET);
            abs_ang_reg <= ABS_ANG_W'(ang_i.value);
            rev_reg     <= spd_s < 0;
            fwd_reg     <= spd_s > 0;
            servo_reg   <= SPULSE_W'(ang_i.value) * SPULSE_W'(SERVO_STEP)
                           + SPULSE_W'(SERVO_BASE);
            mprod_reg   <= MPROD_W'(spd_abs) * MPROD_W'(period_i);
        end
        if (a_vld_reg) begin
            qprod_reg <= DIV100_P_W'(mprod_reg) * DIV100_P_W'(DIV100_MUL);
        end
        if (load) begin
            m_data_reg <= {1'b0, servo_reg, qprod_reg[DIV100_SHIFT +: MPULSE_W],
                           fwd_reg, rev_reg, abs_ang_reg, angle_reg, abs_spd_reg,
                           speed_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_vld_reg <= start_i;
            if (a_vld_reg) begin
                b_vld_reg <= 1'b1;
            end else if (load) begin
                b_vld_reg <= 1'b0;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready_i) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid_o = m_valid_reg;
    assign m_data_o  = m_data_reg;
    assign loaded_o  = load;

endmodule

/* tb/pot_average_motor_servo_pwm_tb.sv */
// Self-checking testbench for pot_average_motor_servo_pwm: streams sample pairs,
// predicts each averaged drive result and compares every result beat field by field.
// Depends on pams_pkg and the pot_average_motor_servo_pwm RTL; reads no files.
module pot_average_motor_servo_pwm_tb;
    import pams_pkg::*;

    // Depth of the averaging rings, passed to the block so both sides agree.
    localparam int RING_DEPTH      = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 210;
    // The slowest correct run is about 1300 beats, plus sender gaps and receiver
    // stalls; the limit leaves a wide margin on that.
    localparam int CYCLE_LIMIT     = 400000;
    // Drain time after the last result.
    localparam int TAIL_CYCLES     = 40;

    // Register map: the only register is at byte address 0; address 4 decodes to
    // nothing and writes there must leave motor_period alone.
    localparam logic [2:0] ADDR_MOTOR_PERIOD = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

    // One result beat as it sits on m_tdata, most significant field first.
    typedef struct packed {
        logic        pad;
        logic [13:0] servo_pulse;
        logic [15:0] motor_pulse;
        logic        drive_forward;
        logic        drive_reverse;
        logic [7:0]  abs_angle;
        logic [7:0]  angle_setting;
        logic [6:0]  abs_speed;
        logic [7:0]  speed_setting;
    } drive_result_t;

    // One line of the directed table. A row may repeat its sample pair so that the
    // rings fill up; a typed expectation applies to the last repetition only.
    typedef struct {
        logic [9:0]    speed;
        logic [9:0]    angle;
        int            reps;
        bit            set_period;
        logic [31:0]   period_word;
        bit            typed;
        drive_result_t want;
    } stim_row_t;

    // All block inputs start at known values before the first clock edge.
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [9:0] speed_sample, [19:10] angle_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [7:0] speed_setting, [14:8] abs_speed, [22:15] angle_setting, [30:23] abs_angle,
    // [31] drive_reverse, [32] drive_forward, [48:33] motor_pulse, [62:49] servo_pulse
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Shadow of the block: both sample rings, the write slot and the period register.
    logic [9:0]    speed_hist [RING_DEPTH];
    logic [9:0]    angle_hist [RING_DEPTH];
    int            hist_slot;
    logic [15:0]   period_shadow;

    drive_result_t pending_drive [$];   // predicted results, oldest first

    int errors          = 0;
    int samples_sent    = 0;
    int drives_checked  = 0;
    int period_settings = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int stall_timer     = 0;
    int stall_pct       = 0;

    stim_row_t directed_rows [6];

    pot_average_motor_servo_pwm #(
        .AVG_DEPTH(RING_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Global watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Packs the eight result fields; signed values are cut to their two's
    // complement field width.
    function automatic drive_result_t result_of(input int spd_set, input int abs_spd,
                                                input int ang_set, input int abs_ang,
                                                input bit rev, input bit fwd,
                                                input int unsigned mpulse,
                                                input int unsigned spulse);
        drive_result_t r;
        r.pad           = 1'b0;
        r.speed_setting = spd_set[7:0];
        r.abs_speed     = abs_spd[6:0];
        r.angle_setting = ang_set[7:0];
        r.abs_angle     = abs_ang[7:0];
        r.drive_reverse = rev;
        r.drive_forward = fwd;
        r.motor_pulse   = mpulse[15:0];
        r.servo_pulse   = spulse[13:0];
        return r;
    endfunction

    // Stores one sample pair in the rings and works out the drive result that the
    // block owes for it. Everything truncates; no value ever saturates.
    function automatic drive_result_t average_and_scale(input logic [9:0] spd,
                                                        input logic [9:0] ang);
        int unsigned sum_s;
        int unsigned sum_a;
        int unsigned scaled_s;
        int unsigned abs_ang;
        int unsigned abs_spd;
        int          spd_set;
        int          ang_set;
        sum_s = 0;
        sum_a = 0;
        speed_hist[hist_slot] = spd;
        angle_hist[hist_slot] = ang;
        hist_slot = (hist_slot == RING_DEPTH - 1) ? 0 : hist_slot + 1;
        for (int k = 0; k < RING_DEPTH; k++) begin
            sum_s += speed_hist[k];
            sum_a += angle_hist[k];
        end
        scaled_s = (198 * (sum_s / RING_DEPTH)) / 1023;
        abs_ang  = (180 * (sum_a / RING_DEPTH)) / 1023;
        spd_set  = int'(scaled_s) - 99;
        ang_set  = int'(abs_ang) - 90;
        abs_spd  = (spd_set < 0) ? -spd_set : spd_set;
        return result_of(spd_set, abs_spd, ang_set, abs_ang, spd_set < 0, spd_set > 0,
                         (abs_spd * period_shadow) / 100, 50 * abs_ang + 2999);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Result side: every accepted beat is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drive.size() == 0) begin
                errors++;
                $display("%0t: result beat %h arrived with none expected", $time, m_tdata);
            end else begin
                drive_result_t want;
                drive_result_t got;
                want = pending_drive.pop_front();
                got  = drive_result_t'(m_tdata);
                check_field("speed_setting", want.speed_setting, got.speed_setting);
                check_field("abs_speed",     want.abs_speed,     got.abs_speed);
                check_field("angle_setting", want.angle_setting, got.angle_setting);
                check_field("abs_angle",     want.abs_angle,     got.abs_angle);
                check_field("drive_reverse", want.drive_reverse, got.drive_reverse);
                check_field("drive_forward", want.drive_forward, got.drive_forward);
                check_field("motor_pulse",   want.motor_pulse,   got.motor_pulse);
                check_field("servo_pulse",   want.servo_pulse,   got.servo_pulse);
                drives_checked++;
            end
        end
    end

    // Receiver backpressure: whenever the stall timer runs out a new stall rate is drawn.
    // Two draws in five give a stretch where the receiver never stalls.
    always @(posedge aclk) begin
        if (stall_timer == 0) begin
            stall_timer = $urandom_range(50, 400);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 30;
                3: stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        stall_timer--;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // A configuration write is a setup phase followed by an access phase that waits for pready.
    // The bus then idles so that back-to-back transfers never lower and raise psel in one step.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_period_readback();
        logic [31:0] rd;
        apb_read(ADDR_MOTOR_PERIOD, rd);
        if (rd !== {16'h0, period_shadow}) begin
            errors++;
            $display("%0t: motor_period read expected %0d got %0d", $time, period_shadow, rd);
        end
    endtask

    // Writes the period (upper word bits are don't-care to the block), pokes the
    // unmapped address, then reads back to show only the low 16 bits were kept.
    task automatic set_motor_period(input logic [31:0] word);
        apb_write(ADDR_MOTOR_PERIOD, word);
        period_shadow = word[15:0];
        apb_write(ADDR_UNMAPPED, $urandom);
        check_period_readback();
        period_settings++;
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_until_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_drive.size() != 0) @(posedge aclk);
    endtask

    // Bursts of random length with random gaps; without gaps the sender keeps
    // tvalid high across beats.
    task automatic pace_sender(input bit idle_gaps);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = idle_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
    endtask

    // Offers one sample pair and records the expected result once the beat is
    // taken. A typed expectation replaces the prediction, but the rings still move.
    task automatic send_samples(input logic [9:0] spd, input logic [9:0] ang,
                                input bit use_typed, input drive_result_t typed_want);
        drive_result_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 20){1'b0}}, ang, spd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = average_and_scale(spd, ang);
        pending_drive.push_back(use_typed ? typed_want : predicted);
        samples_sent++;
    endtask

    // Run centers: the rail values, the band around mid-scale where the speed
    // rounds to zero, or anywhere.
    function automatic logic [9:0] pick_center();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'($urandom_range(505, 520));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [9:0] jittered(input logic [9:0] center, input int spread);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return v[9:0];
    endfunction

    // Mostly runs around one center, often long enough to fill the rings, so averages
    // reach the ends of the scale; the rest are short bursts of pure noise.
    task automatic random_phase(input int n_items, input bit idle_gaps);
        int          left;
        int          mode;
        int          run_len;
        int          spread;
        logic [9:0]  center_s;
        logic [9:0]  center_a;
        logic [9:0]  spd;
        logic [9:0]  ang;
        left = n_items;
        while (left > 0) begin
            mode     = $urandom_range(0, 9);
            run_len  = (mode < 7) ? $urandom_range(RING_DEPTH / 2, 2 * RING_DEPTH + 4)
                                  : $urandom_range(1, 6);
            center_s = pick_center();
            center_a = pick_center();
            spread   = $urandom_range(0, 16);
            for (int k = 0; k < run_len && left > 0; k++) begin
                if (mode < 7) begin
                    spd = jittered(center_s, spread);
                    ang = jittered(center_a, spread);
                end else begin
                    spd = 10'($urandom_range(0, 1023));
                    ang = 10'($urandom_range(0, 1023));
                end
                pace_sender(idle_gaps);
                send_samples(spd, ang, 1'b0, '0);
                left--;
            end
            // Now and then the sender holds off until the block has fully drained.
            if ($urandom_range(0, 29) == 0) wait_until_quiet();
        end
    endtask

    initial begin
        logic [15:0] period;

        for (int k = 0; k < RING_DEPTH; k++) begin
            speed_hist[k] = '0;
            angle_hist[k] = '0;
        end
        hist_slot     = 0;
        period_shadow = '0;

        // Directed table. Typed rows: the first beat after reset sees an empty
        // ring (full reverse, servo at its base), a ring full of maximum samples
        // gives full forward and full angle, the same with the widest period gives
        // the largest motor pulse, and a ring of mid-scale samples lands on zero
        // speed. The period word carries set upper bits that must be dropped.
        directed_rows[0] = '{10'd0, 10'd0, 1, 1'b0, 32'h0, 1'b1,
                             result_of(-99, 99, -90, 0, 1'b1, 1'b0, 0, 2999)};
        directed_rows[1] = '{10'd1023, 10'd1023, RING_DEPTH, 1'b0, 32'h0, 1'b1,
                             result_of(99, 99, 90, 180, 1'b0, 1'b1, 0, 11999)};
        directed_rows[2] = '{10'd1023, 10'd1023, 1, 1'b1, 32'hFFFF_FFFF, 1'b1,
                             result_of(99, 99, 90, 180, 1'b0, 1'b1, 64879, 11999)};
        directed_rows[3] = '{10'd512, 10'd512, RING_DEPTH, 1'b0, 32'h0, 1'b1,
                             result_of(0, 0, 0, 90, 1'b0, 1'b0, 0, 7499)};
        directed_rows[4] = '{10'h2AA, 10'h155, 1, 1'b0, 32'h0, 1'b0, '0};
        directed_rows[5] = '{10'h155, 10'h2AA, 1, 1'b0, 32'h0, 1'b0, '0};

        // Reset is applied once, at the start of the run.
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The period register must read back as zero out of reset.
        check_period_readback();

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_period) begin
                wait_until_quiet();
                set_motor_period(directed_rows[i].period_word);
            end
            for (int r = 0; r < directed_rows[i].reps; r++) begin
                pace_sender(1'b1);
                send_samples(directed_rows[i].speed, directed_rows[i].angle,
                             directed_rows[i].typed && (r == directed_rows[i].reps - 1),
                             directed_rows[i].want);
            end
        end

        // Random part: each phase drains the block, moves the period to a new
        // setting (both extremes first) and streams a fresh batch of samples.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: period = 16'hFFFF;
                1: period = 16'h0000;
                2: period = 16'd1;
                3: period = 16'd100;
                default: period = 16'($urandom_range(0, 65535));
            endcase
            wait_until_quiet();
            set_motor_period({16'($urandom), period});
            random_phase(ITEMS_PER_PHASE, (phase % 3) != 1);
        end

        // Let the last results come home, then allow a short tail so that any
        // stray extra beat is still caught.
        wait_until_quiet();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Streamed %0d sample beats across %0d motor period settings; %0d results compared.",
                 samples_sent, period_settings, drives_checked);
        $display("Covered full reverse, zero speed, full forward and period values from 0 to 65535.");
        if (errors == 0 && pending_drive.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results never arrived", errors, pending_drive.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
